FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the range RNG.
// Needs a clock and an active-low reset at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define LFR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be seen outside reset
`define LFR_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LFR_ASSERT(label, clk, rst_n, prop, msg)
`define LFR_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/lfr_pkg.sv
// Types and constants of the lagged Fibonacci range RNG.
// No dependencies; used by lfr_mod_unit and lagged_fibonacci_range_rng.
`timescale 1ns / 1ps

package lfr_pkg;

  localparam int WordW = 32;
  localparam int SpanW = WordW + 1;

  // first ring word after reset; entry k holds RingBase + k
  localparam logic [WordW-1:0] RingBase = 32'd1000001;

  typedef enum logic {
    KindReseed = 1'b0,
    KindDraw   = 1'b1
  } lfr_kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StRotate,
    StDiv,
    StPush
  } lfr_state_e;

  typedef struct packed {
    lfr_kind_e               kind;
    logic [WordW-1:0]        seed;
    logic signed [WordW-1:0] low_bound;
    logic signed [WordW-1:0] high_bound;
  } lfr_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic [WordW-1:0]        raw_word;
  } lfr_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lfr_mod_stat_t;

endpackage

FILE: rtl/lagged_fibonacci_range_rng.sv
// Top level: additive lagged Fibonacci RNG (lags LONG_LAG, SHORT_LAG) with range reduction.
// Depends on lfr_pkg, lfr_mod_unit and assert_macros.svh.
//
//   channel | signals                            | payload
//   in      | in_valid_i  / in_ready_o           | lfr_pkg::lfr_in_t  (kind, seed, bounds)
//   out     | out_valid_o / out_ready_i          | lfr_pkg::lfr_out_t (value, raw_word)
//
// Draw: ring update on the accepting edge, then the remainder unit runs; once it is done
//   the result is registered into the output register, and the input opens for the next
//   beat once that result is loaded.
// Reseed: XOR on the accepting edge, then ring rotation until the position wraps to 0
//   (none when position is 0); no result beat.
// A finished result waits in the output register while the next beat is taken; a
//   draw that finishes while that register is still full holds until it drains.
// Reset loads the ring with its seed words and zeroes the position.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lagged_fibonacci_range_rng #(
  parameter int LONG_LAG  = 17,
  parameter int SHORT_LAG = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lfr_pkg::lfr_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lfr_pkg::lfr_out_t  out_data_o
);

  localparam int PosW    = $clog2(LONG_LAG);
  // a draw shifts the ring so the oldest word sits at entry 0
  localparam int NearIdx = (LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG;

  lfr_pkg::lfr_state_e state_q, state_d;
  logic [lfr_pkg::WordW-1:0]        ring_q [LONG_LAG];
  logic [lfr_pkg::WordW-1:0]        ring_d [LONG_LAG];
  logic [PosW-1:0]                  pos_q, pos_d, pos_inc;
  logic signed [lfr_pkg::WordW-1:0] lo_q, lo_d;
  logic [lfr_pkg::WordW-1:0]        raw_q, raw_d;
  logic                             out_valid_q, out_valid_d;
  lfr_pkg::lfr_out_t                out_q, out_d;

  logic                             in_acc;
  logic                             is_draw;
  logic                             can_load;
  logic                             load_out;
  logic [lfr_pkg::WordW-1:0]        sum;
  logic signed [lfr_pkg::WordW-1:0] lo_in, hi_in, lo_sel, hi_sel;
  logic [lfr_pkg::SpanW-1:0]        span;
  logic                             mod_start;
  lfr_pkg::lfr_mod_stat_t           mod_stat;
  logic [lfr_pkg::SpanW-1:0]        mod_rem;

  assign in_ready_o = (state_q == lfr_pkg::StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_draw    = (in_data_i.kind == lfr_pkg::KindDraw);
  assign mod_start  = in_acc && is_draw;
  assign can_load   = !out_valid_q || out_ready_i;

  assign sum     = ring_q[0] + ring_q[NearIdx];
  assign pos_inc = (pos_q == PosW'(LONG_LAG - 1)) ? '0 : pos_q + 1'b1;

  assign lo_in  = in_data_i.low_bound;
  assign hi_in  = in_data_i.high_bound;
  assign lo_sel = (lo_in > hi_in) ? hi_in : lo_in;
  assign hi_sel = (lo_in > hi_in) ? lo_in : hi_in;
  assign span   = {hi_sel[lfr_pkg::WordW-1], hi_sel} - {lo_sel[lfr_pkg::WordW-1], lo_sel}
                  + 1'b1;

  lfr_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (sum),
    .divisor_i  (span),
    .stat_o     (mod_stat),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d  = state_q;
    ring_d   = ring_q;
    pos_d    = pos_q;
    lo_d     = lo_q;
    raw_d    = raw_q;
    load_out = 1'b0;
    case (state_q)
      lfr_pkg::StIdle: begin
        if (in_acc) begin
          if (is_draw) begin
            for (int k = 0; k < LONG_LAG - 1; k++) begin
              ring_d[k] = ring_q[k + 1];
            end
            ring_d[LONG_LAG-1] = sum;
            pos_d   = pos_inc;
            lo_d    = lo_sel;
            raw_d   = sum;
            state_d = lfr_pkg::StDiv;
          end else begin
            for (int k = 0; k < LONG_LAG; k++) begin
              ring_d[k] = ring_q[k] ^ in_data_i.seed;
            end
            // realign the ring to its reset layout: rotate until the position wraps to 0
            if (pos_q != '0) begin
              state_d = lfr_pkg::StRotate;
            end
          end
        end
      end
      lfr_pkg::StRotate: begin
        for (int k = 0; k < LONG_LAG - 1; k++) begin
          ring_d[k] = ring_q[k + 1];
        end
        ring_d[LONG_LAG-1] = ring_q[0];
        pos_d = pos_inc;
        if (pos_inc == '0) begin
          state_d = lfr_pkg::StIdle;
        end
      end
      lfr_pkg::StDiv: begin
        if (mod_stat.done) begin
          if (can_load) begin
            load_out = 1'b1;
            state_d  = lfr_pkg::StIdle;
          end else begin
            state_d = lfr_pkg::StPush;
          end
        end
      end
      lfr_pkg::StPush: begin
        if (can_load) begin
          load_out = 1'b1;
          state_d  = lfr_pkg::StIdle;
        end
      end
      default: begin
        state_d = lfr_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d    = 1'b1;
      // offset is below the span, so its low word is exact
      out_d.value    = lo_q + mod_rem[lfr_pkg::WordW-1:0];
      out_d.raw_word = raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfr_pkg::StIdle;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < LONG_LAG; k++) begin
        ring_q[k] <= lfr_pkg::RingBase + lfr_pkg::WordW'(k);
      end
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      ring_q      <= ring_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    raw_q <= raw_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LFR_ASSERT(a_draw_starts_mod, clk_i, rst_ni, mod_start |=> mod_stat.busy, "draw did not start remainder unit")
  `LFR_ASSERT(a_draw_blocks_input, clk_i, rst_ni, mod_start |=> !in_ready_o, "input open during draw")
  `LFR_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PosW'(LONG_LAG - 1), "ring position out of range")
  `LFR_ASSERT(a_done_in_div, clk_i, rst_ni, mod_stat.done |-> (state_q == lfr_pkg::StDiv), "remainder done outside divide state")
  `LFR_ASSERT(a_load_has_room, clk_i, rst_ni, load_out |-> can_load, "result overwrote pending beat")

endmodule

FILE: rtl/lfr_mod_unit.sv
// Iterative restoring remainder unit: 32-bit word mod 33-bit span.
// Depends on lfr_pkg and assert_macros.svh. One quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfr_mod_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lfr_pkg::WordW-1:0]   dividend_i,
  input  logic [lfr_pkg::SpanW-1:0]   divisor_i,
  output lfr_pkg::lfr_mod_stat_t      stat_o,
  output logic [lfr_pkg::SpanW-1:0]   rem_o
);

  localparam int CntW = $clog2(lfr_pkg::WordW);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [lfr_pkg::WordW-1:0]   dvd_q, dvd_d;
  logic [lfr_pkg::SpanW-1:0]   dsr_q, dsr_d;
  logic [lfr_pkg::SpanW-1:0]   rem_q, rem_d;
  logic [lfr_pkg::SpanW:0]     trial;
  logic [lfr_pkg::SpanW:0]     diff;

  // remainder stays below the span (at most 2^32), so trial never sets its top bit
  assign trial = {rem_q, dvd_q[lfr_pkg::WordW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = diff[lfr_pkg::SpanW] ? trial[lfr_pkg::SpanW-1:0] : diff[lfr_pkg::SpanW-1:0];
      dvd_d = {dvd_q[lfr_pkg::WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(lfr_pkg::WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

  `LFR_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy_q, "mod unit restarted mid-run")
  `LFR_NEVER(a_done_and_busy, clk_i, rst_ni, done_q && busy_q, "mod unit done while busy")
  `LFR_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "mod unit done held")
  `LFR_ASSERT(a_done_after_last, clk_i, rst_ni, done_q |-> $past(busy_q), "done without a run")

endmodule
